FILE: hw/rtl/vuc_pkg.sv
// Shared types, codes and microcode table for the viewport unit converter.
`default_nettype none
package vuc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int FIELD_BITS = 32;
	localparam int IN_BYTES_W = 144;
	localparam int OUT_BYTES_W = 72;
	localparam int CFG_IDX_W = 3;

	// function codes
	localparam logic [2:0] FN_CONV = 3'd0;
	localparam logic [2:0] FN_ADD  = 3'd1;
	localparam logic [2:0] FN_SUB  = 3'd2;
	localparam logic [2:0] FN_MUL  = 3'd3;
	localparam logic [2:0] FN_DIV  = 3'd4;

	// unit codes
	localparam logic [2:0] U_VPCT  = 3'd0;
	localparam logic [2:0] U_VPX   = 3'd1;
	localparam logic [2:0] U_VUNIT = 3'd2;
	localparam logic [2:0] U_WPX   = 3'd3;
	localparam logic [2:0] U_WUNIT = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_UNKNOWN = 2'd1;
	localparam logic [1:0] STAT_DIVZERO = 2'd2;
	localparam logic [1:0] STAT_SAT     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_LEFT     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_TOP      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT   = 3'd5;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_IMUL, OP_IDIV, OP_QMUL, OP_QDIV
	} op_t;

	// T: running value, U: scratch, P: point, O: origin, E: extent
	typedef enum logic [2:0] {
		SRC_T, SRC_U, SRC_P, SRC_O, SRC_E
	} src_t;

	typedef struct packed {
		op_t  op;
		src_t sa;
		src_t sb;
		logic to_u;
	} uop_t;

	typedef struct packed {
		logic [1:0]     len;
		uop_t [3:0]     ops;
	} prog_t;

	typedef struct packed {
		logic        unknown;
		logic [2:0]  ru;
		logic        comb;
		op_t         comb_op;
		prog_t       prog;
		logic [31:0] a_x;
		logic [31:0] a_y;
		logic [31:0] p_x;
		logic [31:0] p_y;
	} work_t;

	typedef struct packed {
		logic [15:0] sw;
		logic [15:0] sh;
		logic [31:0] vl;
		logic [31:0] vt;
		logic [31:0] vw;
		logic [31:0] vh;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic is_div;
		logic frac;
	} md_req_t;

	typedef enum logic [2:0] {
		B_IDLE, B_AXIS, B_STEP, B_WAIT, B_FIN, B_DONE
	} bst_t;

	function automatic uop_t mk_uop(op_t op, src_t sa, src_t sb, logic to_u);
		uop_t u;
		u.op = op;
		u.sa = sa;
		u.sb = sb;
		u.to_u = to_u;
		return u;
	endfunction

	// Per-axis conversion program; IMUL/IDIV take the screen size as second operand.
	function automatic prog_t conv_prog(logic [2:0] from_u, logic [2:0] to_u);
		prog_t p;
		p = '0;
		if (from_u != to_u) begin
			case (to_u)
				U_VPCT: begin
					case (from_u)
						U_VPX: begin
							p.len = 2'd1;
							p.ops[0] = mk_uop(OP_IDIV, SRC_P, SRC_T, 1'b0);
						end
						U_VUNIT: begin
							p.len = 2'd1;
							p.ops[0] = mk_uop(OP_QDIV, SRC_P, SRC_E, 1'b0);
						end
						U_WPX: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_IDIV, SRC_P, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QDIV, SRC_O, SRC_E, 1'b1);
							p.ops[2] = mk_uop(OP_SUB, SRC_T, SRC_U, 1'b0);
						end
						default: begin
							p.len = 2'd2;
							p.ops[0] = mk_uop(OP_SUB, SRC_P, SRC_O, 1'b0);
							p.ops[1] = mk_uop(OP_QDIV, SRC_T, SRC_E, 1'b0);
						end
					endcase
				end
				U_VPX: begin
					case (from_u)
						U_VPCT: begin
							p.len = 2'd1;
							p.ops[0] = mk_uop(OP_IMUL, SRC_P, SRC_T, 1'b0);
						end
						U_VUNIT: begin
							p.len = 2'd2;
							p.ops[0] = mk_uop(OP_IMUL, SRC_P, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QDIV, SRC_T, SRC_E, 1'b0);
						end
						U_WPX: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_IMUL, SRC_O, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QDIV, SRC_T, SRC_E, 1'b0);
							p.ops[2] = mk_uop(OP_SUB, SRC_P, SRC_T, 1'b0);
						end
						default: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_SUB, SRC_P, SRC_O, 1'b0);
							p.ops[1] = mk_uop(OP_QDIV, SRC_T, SRC_E, 1'b0);
							p.ops[2] = mk_uop(OP_IMUL, SRC_T, SRC_T, 1'b0);
						end
					endcase
				end
				U_VUNIT: begin
					case (from_u)
						U_VPCT: begin
							p.len = 2'd1;
							p.ops[0] = mk_uop(OP_QMUL, SRC_P, SRC_E, 1'b0);
						end
						U_VPX: begin
							p.len = 2'd2;
							p.ops[0] = mk_uop(OP_IDIV, SRC_P, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QMUL, SRC_T, SRC_E, 1'b0);
						end
						U_WPX: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_QMUL, SRC_P, SRC_E, 1'b0);
							p.ops[1] = mk_uop(OP_IDIV, SRC_T, SRC_T, 1'b0);
							p.ops[2] = mk_uop(OP_SUB, SRC_T, SRC_O, 1'b0);
						end
						default: begin
							p.len = 2'd1;
							p.ops[0] = mk_uop(OP_SUB, SRC_P, SRC_O, 1'b0);
						end
					endcase
				end
				U_WPX: begin
					case (from_u)
						U_VPCT: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_QDIV, SRC_O, SRC_E, 1'b0);
							p.ops[1] = mk_uop(OP_ADD, SRC_T, SRC_P, 1'b0);
							p.ops[2] = mk_uop(OP_IMUL, SRC_T, SRC_T, 1'b0);
						end
						U_VPX: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_IMUL, SRC_O, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QDIV, SRC_T, SRC_E, 1'b0);
							p.ops[2] = mk_uop(OP_ADD, SRC_T, SRC_P, 1'b0);
						end
						U_VUNIT: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_ADD, SRC_O, SRC_P, 1'b0);
							p.ops[1] = mk_uop(OP_IMUL, SRC_T, SRC_T, 1'b0);
							p.ops[2] = mk_uop(OP_QDIV, SRC_T, SRC_E, 1'b0);
						end
						default: begin
							p.len = 2'd2;
							p.ops[0] = mk_uop(OP_QDIV, SRC_P, SRC_E, 1'b0);
							p.ops[1] = mk_uop(OP_IMUL, SRC_T, SRC_T, 1'b0);
						end
					endcase
				end
				default: begin
					case (from_u)
						U_VPCT: begin
							p.len = 2'd2;
							p.ops[0] = mk_uop(OP_QMUL, SRC_E, SRC_P, 1'b0);
							p.ops[1] = mk_uop(OP_ADD, SRC_T, SRC_O, 1'b0);
						end
						U_VPX: begin
							p.len = 2'd3;
							p.ops[0] = mk_uop(OP_IDIV, SRC_P, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QMUL, SRC_E, SRC_T, 1'b0);
							p.ops[2] = mk_uop(OP_ADD, SRC_T, SRC_O, 1'b0);
						end
						U_VUNIT: begin
							p.len = 2'd1;
							p.ops[0] = mk_uop(OP_ADD, SRC_O, SRC_P, 1'b0);
						end
						default: begin
							p.len = 2'd2;
							p.ops[0] = mk_uop(OP_IDIV, SRC_P, SRC_T, 1'b0);
							p.ops[1] = mk_uop(OP_QMUL, SRC_T, SRC_E, 1'b0);
						end
					endcase
				end
			endcase
		end
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/vuc_front.sv
// Front end: unpacks an input transaction and classifies it into a work item.
`default_nettype none
module vuc_front (
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [vuc_pkg::IN_BYTES_W-1:0]   s_tdata,
	input  wire logic                             q_full,
	output logic                                  q_push,
	output vuc_pkg::work_t                        q_item
);

	logic [2:0] func, a_unit, b_unit, target_unit, from_u, to_u;
	logic       is_conv;

	assign func        = s_tdata[2:0];
	assign a_unit      = s_tdata[69:67];
	assign b_unit      = s_tdata[136:134];
	assign target_unit = s_tdata[139:137];
	assign is_conv     = (func == vuc_pkg::FN_CONV);
	assign from_u      = is_conv ? a_unit : b_unit;
	assign to_u        = is_conv ? target_unit : a_unit;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	always_comb begin
		q_item.unknown = (func > vuc_pkg::FN_DIV) || (a_unit > vuc_pkg::U_WUNIT)
			|| (is_conv ? (target_unit > vuc_pkg::U_WUNIT) : (b_unit > vuc_pkg::U_WUNIT));
		q_item.ru   = is_conv ? target_unit : a_unit;
		q_item.comb = !is_conv;
		case (func)
			vuc_pkg::FN_SUB: q_item.comb_op = vuc_pkg::OP_SUB;
			vuc_pkg::FN_MUL: q_item.comb_op = vuc_pkg::OP_QMUL;
			vuc_pkg::FN_DIV: q_item.comb_op = vuc_pkg::OP_QDIV;
			default:         q_item.comb_op = vuc_pkg::OP_ADD;
		endcase
		q_item.prog = vuc_pkg::conv_prog(from_u, to_u);
		q_item.a_x  = s_tdata[34:3];
		q_item.a_y  = s_tdata[66:35];
		q_item.p_x  = is_conv ? s_tdata[34:3] : s_tdata[101:70];
		q_item.p_y  = is_conv ? s_tdata[66:35] : s_tdata[133:102];
	end

endmodule
`default_nettype wire

FILE: hw/rtl/vuc_fifo.sv
// Short work queue between front and back end.
`default_nettype none
module vuc_fifo #(
	parameter int DEPTH = vuc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  vuc_pkg::work_t      din,
	output logic                full,
	input  wire logic           pop,
	output vuc_pkg::work_t      dout,
	output logic                empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	vuc_pkg::work_t mem_q [DEPTH];
	logic [AW:0] wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full  = (wp_q[AW] != rp_q[AW]) && (wp_q[AW-1:0] == rp_q[AW-1:0]);
	assign dout  = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push && !full) wp_q <= wp_q + 1'b1;
			if (pop && !empty) rp_q <= rp_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q[AW-1:0]] <= din;
	end

endmodule
`default_nettype wire

FILE: hw/rtl/vuc_muldiv.sv
// Iterative magnitude multiply (shift-add) and restoring divide, one bit per cycle.
`default_nettype none
module vuc_muldiv #(
	parameter int FRAC_BITS = vuc_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = vuc_pkg::WORD_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  vuc_pkg::md_req_t              req,
	input  wire logic [WORD_BITS-1:0]     x,
	input  wire logic [WORD_BITS-1:0]     y,
	output logic                          done,
	output logic [2*WORD_BITS-1:0]        res
);

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int N  = W + F;
	localparam int RW = 2 * W;
	localparam int CW = $clog2(N + 1);

	logic          busy_q, fin_q, done_q, is_div_q, frac_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  oth_q;
	logic [RW-1:0] acc_q;
	logic [N-1:0]  d_q;
	logic [W:0]    rem_q;

	logic [W:0]    msum;
	logic [W:0]    r2;
	logic          ge;

	assign msum = {1'b0, acc_q[RW-1:W]} + (acc_q[0] ? {1'b0, oth_q} : '0);
	assign r2   = {rem_q[W-1:0], d_q[N-1]};
	assign ge   = (r2 >= {1'b0, oth_q});
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.is_div ? CW'(N) : CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_div_q <= req.is_div;
			frac_q   <= req.frac;
			rem_q    <= '0;
			if (req.is_div) begin
				oth_q <= y;
				d_q   <= req.frac ? (N'(x) << F) : N'(x);
			end else begin
				oth_q <= x;
				acc_q <= {{W{1'b0}}, y};
			end
		end else if (busy_q) begin
			if (is_div_q) begin
				rem_q <= ge ? (r2 - {1'b0, oth_q}) : r2;
				d_q   <= {d_q[N-2:0], ge};
			end else begin
				acc_q <= {msum, acc_q[W-1:1]};
			end
		end
		if (fin_q) begin
			if (is_div_q) res <= RW'(d_q);
			else if (frac_q) res <= (acc_q + (RW'(1) << (F - 1))) >> F;
			else res <= acc_q;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/vuc_back.sv
// Back end: microcode sequencer per axis, saturating ALU and output register.
`default_nettype none
module vuc_back #(
	parameter int FRAC_BITS = vuc_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS = vuc_pkg::WORD_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  vuc_pkg::cfg_t                        cfg,
	input  wire logic                            q_empty,
	input  vuc_pkg::work_t                       q_item,
	output logic                                 q_pop,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [vuc_pkg::OUT_BYTES_W-1:0]      m_tdata
);

	localparam int W  = WORD_BITS;
	localparam int RW = 2 * W;
	localparam int EW = (W > 32) ? W : 32;

	typedef logic [W-1:0] word_t;

	function automatic word_t win_val(logic [31:0] v);
		logic signed [EW-1:0] ev, mx, mn;
		ev = EW'($signed(v));
		mx = EW'((EW'(1) << (W - 1)) - EW'(1));
		mn = ~mx;
		if (ev > mx) return W'(mx);
		if (ev < mn) return W'(mn);
		return W'(ev);
	endfunction

	function automatic logic win_sat(logic [31:0] v);
		logic signed [EW-1:0] ev, mx, mn;
		ev = EW'($signed(v));
		mx = EW'((EW'(1) << (W - 1)) - EW'(1));
		mn = ~mx;
		return (ev > mx) || (ev < mn);
	endfunction

	function automatic logic [31:0] fclamp(word_t v);
		logic signed [EW-1:0] ev, mx, mn;
		ev = EW'($signed(v));
		mx = EW'((EW'(1) << 31) - EW'(1));
		mn = ~mx;
		if (ev > mx) return mx[31:0];
		if (ev < mn) return mn[31:0];
		return ev[31:0];
	endfunction

	function automatic logic fsat(word_t v);
		logic signed [EW-1:0] ev, mx, mn;
		ev = EW'($signed(v));
		mx = EW'((EW'(1) << 31) - EW'(1));
		mn = ~mx;
		return (ev > mx) || (ev < mn);
	endfunction

	function automatic word_t mag(word_t v);
		return v[W-1] ? (~v + 1'b1) : v;
	endfunction

	vuc_pkg::bst_t   state_q, state_d;
	vuc_pkg::work_t  item_q;
	logic            axis_q, dz_q, sat_q, m_valid_q;
	logic [1:0]      step_q;
	word_t           t_q, u_q, rx_q, ry_q;
	logic [vuc_pkg::OUT_BYTES_W-1:0] m_data_q;

	// per-axis operands
	word_t        a_w, p_w, o_w, e_w, x_val, y_val, x_mag, y_mag;
	logic [15:0]  s_cur;
	vuc_pkg::uop_t uop;
	vuc_pkg::op_t  cur_op;
	logic          cmb_now, mv_now, end_axis, to_u, is_md, use_s, is_div_op, neg, dz_now;
	logic          step_imm, in_sat;

	// ALU results
	logic [W:0]    xe, ye, as_sum;
	word_t         as_val, dz_val, sm_val, wr_val;
	logic          as_sat, sm_sat, wr_sat, wr_dz, wr_en, init_axis, out_load;
	logic [RW-1:0] lim, mm;

	vuc_pkg::md_req_t md_req;
	logic             md_done;
	logic [RW-1:0]    md_res;

	logic [31:0] fx, fy;
	logic [1:0]  stat;

	function automatic word_t sel(vuc_pkg::src_t s, word_t t, word_t u, word_t p, word_t o,
			word_t e);
		case (s)
			vuc_pkg::SRC_T: return t;
			vuc_pkg::SRC_U: return u;
			vuc_pkg::SRC_P: return p;
			vuc_pkg::SRC_O: return o;
			default:        return e;
		endcase
	endfunction

	always_comb begin
		a_w   = axis_q ? win_val(item_q.a_y) : win_val(item_q.a_x);
		p_w   = axis_q ? win_val(item_q.p_y) : win_val(item_q.p_x);
		o_w   = axis_q ? win_val(cfg.vt) : win_val(cfg.vl);
		e_w   = axis_q ? win_val(cfg.vh) : win_val(cfg.vw);
		s_cur = axis_q ? cfg.sh : cfg.sw;
		uop     = item_q.prog.ops[step_q];
		cmb_now = (step_q == item_q.prog.len) && item_q.comb;
		mv_now  = (step_q == item_q.prog.len) && !item_q.comb;
		end_axis = cmb_now || mv_now;
		cur_op  = cmb_now ? item_q.comb_op : uop.op;
		to_u    = !cmb_now && uop.to_u;
		x_val   = cmb_now ? a_w : sel(uop.sa, t_q, u_q, p_w, o_w, e_w);
		y_val   = cmb_now ? t_q : sel(uop.sb, t_q, u_q, p_w, o_w, e_w);
	end

	always_comb begin
		unique case (cur_op) inside
			vuc_pkg::OP_IMUL, vuc_pkg::OP_IDIV: begin
				is_md = 1'b1;
				use_s = 1'b1;
			end
			vuc_pkg::OP_QMUL, vuc_pkg::OP_QDIV: begin
				is_md = 1'b1;
				use_s = 1'b0;
			end
			default: begin
				is_md = 1'b0;
				use_s = 1'b0;
			end
		endcase
		is_div_op = (cur_op == vuc_pkg::OP_IDIV) || (cur_op == vuc_pkg::OP_QDIV);
		x_mag  = mag(x_val);
		y_mag  = use_s ? W'(s_cur) : mag(y_val);
		neg    = x_val[W-1] ^ (!use_s && y_val[W-1]);
		dz_now = is_div_op && (y_mag == '0);
		if (x_val == '0) dz_val = '0;
		else if (x_val[W-1]) dz_val = {1'b1, {(W-1){1'b0}}};
		else dz_val = {1'b0, {(W-1){1'b1}}};
		step_imm = mv_now || !is_md || dz_now;
	end

	// saturating add / subtract
	always_comb begin
		xe = {x_val[W-1], x_val};
		ye = {y_val[W-1], y_val};
		as_sum = (cur_op == vuc_pkg::OP_SUB) ? (xe - ye) : (xe + ye);
		as_sat = as_sum[W] ^ as_sum[W-1];
		if (as_sat) as_val = as_sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else as_val = as_sum[W-1:0];
	end

	// sign-magnitude recombination of the iterative unit's result
	always_comb begin
		lim    = neg ? (RW'(1) << (W - 1)) : ((RW'(1) << (W - 1)) - RW'(1));
		sm_sat = (md_res > lim);
		mm     = sm_sat ? lim : md_res;
		sm_val = neg ? (~mm[W-1:0] + 1'b1) : mm[W-1:0];
	end

	assign in_sat = win_sat(q_item.a_x) || win_sat(q_item.a_y) || win_sat(q_item.p_x)
		|| win_sat(q_item.p_y) || win_sat(cfg.vl) || win_sat(cfg.vt) || win_sat(cfg.vw)
		|| win_sat(cfg.vh);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vuc_pkg::B_IDLE: if (!q_empty) state_d = q_item.unknown ? vuc_pkg::B_DONE
				: vuc_pkg::B_AXIS;
			vuc_pkg::B_AXIS: state_d = vuc_pkg::B_STEP;
			vuc_pkg::B_STEP: begin
				if (!step_imm) state_d = vuc_pkg::B_WAIT;
				else if (end_axis) state_d = axis_q ? vuc_pkg::B_DONE : vuc_pkg::B_AXIS;
			end
			vuc_pkg::B_WAIT: if (md_done) state_d = vuc_pkg::B_FIN;
			vuc_pkg::B_FIN: begin
				if (end_axis) state_d = axis_q ? vuc_pkg::B_DONE : vuc_pkg::B_AXIS;
				else state_d = vuc_pkg::B_STEP;
			end
			vuc_pkg::B_DONE: if (!m_valid_q || m_tready) state_d = vuc_pkg::B_IDLE;
			default: state_d = vuc_pkg::B_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop     = 1'b0;
		init_axis = 1'b0;
		wr_en     = 1'b0;
		out_load  = 1'b0;
		md_req    = '0;
		wr_val    = t_q;
		wr_sat    = 1'b0;
		wr_dz     = 1'b0;
		unique case (state_q)
			vuc_pkg::B_IDLE: q_pop = !q_empty;
			vuc_pkg::B_AXIS: init_axis = 1'b1;
			vuc_pkg::B_STEP: begin
				if (step_imm) begin
					wr_en = 1'b1;
					if (mv_now) wr_val = t_q;
					else if (dz_now) begin
						wr_val = dz_val;
						wr_dz  = 1'b1;
					end else begin
						wr_val = as_val;
						wr_sat = as_sat;
					end
				end else begin
					md_req.start  = 1'b1;
					md_req.is_div = is_div_op;
					md_req.frac   = !use_s;
				end
			end
			vuc_pkg::B_WAIT: ;
			vuc_pkg::B_FIN: begin
				wr_en  = 1'b1;
				wr_val = sm_val;
				wr_sat = sm_sat;
			end
			vuc_pkg::B_DONE: out_load = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	always_comb begin
		fx = fclamp(rx_q);
		fy = fclamp(ry_q);
		if (item_q.unknown) stat = vuc_pkg::STAT_UNKNOWN;
		else if (dz_q) stat = vuc_pkg::STAT_DIVZERO;
		else if (sat_q || fsat(rx_q) || fsat(ry_q)) stat = vuc_pkg::STAT_SAT;
		else stat = vuc_pkg::STAT_OK;
	end

	vuc_muldiv #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_BITS (WORD_BITS)
	) u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.x      (x_mag),
		.y      (y_mag),
		.done   (md_done),
		.res    (md_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vuc_pkg::B_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) m_valid_q <= 1'b1;
			else if (m_tready) m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
			axis_q <= 1'b0;
			dz_q   <= 1'b0;
			sat_q  <= in_sat;
		end
		if (init_axis) begin
			t_q    <= p_w;
			step_q <= '0;
		end
		if (wr_en) begin
			if (wr_sat) sat_q <= 1'b1;
			if (wr_dz) dz_q <= 1'b1;
			if (end_axis) begin
				if (axis_q) ry_q <= wr_val;
				else rx_q <= wr_val;
				axis_q <= 1'b1;
			end else begin
				if (to_u) u_q <= wr_val;
				else t_q <= wr_val;
				step_q <= step_q + 2'd1;
			end
		end
		if (out_load) begin
			if (item_q.unknown) m_data_q <= {3'b000, stat, item_q.ru, 64'd0};
			else m_data_q <= {3'b000, stat, item_q.ru, fy, fx};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule
`default_nettype wire

FILE: hw/rtl/viewport_unit_converter_unit.sv
// Top level of the viewport unit converter: config registers, front, queue, back.
//
// Usage:
//   Input transactions arrive on s_tvalid/s_tready/s_tdata, one request each
//   (function, vector A with unit, vector B with unit, target unit). Each gives
//   exactly one result transaction on m_tvalid/m_tready/m_tdata.
//   Screen size and view rectangle are written on cfg_valid/cfg_index/cfg_data;
//   cfg_ready is always high, writes are expected only while the block is idle.
//   The front decodes a request and pushes it into a QUEUE_DEPTH-entry queue,
//   one per cycle while the queue has room, so the sender is not held up by
//   the back end. The back end runs each axis as a short microcode program of
//   up to four operations through one shared bit-serial multiply/divide unit.
//   An add/sub step completes in the step state itself; a multiply or divide
//   starts the shared unit, waits for it to finish, then writes its result back.
//   Sustained rate is set by that shared unit.
//   The result sits in an output register; while the receiver stalls the back
//   end finishes the next item and waits, and the queue keeps accepting.
//   Reset restores 1920x1080 screen, view origin 0 and size 1.0, empties the
//   queue and drops any pending result.
`default_nettype none
module viewport_unit_converter_unit #(
	parameter int FRAC_BITS   = vuc_pkg::FRAC_BITS_DEF,
	parameter int WORD_BITS   = vuc_pkg::WORD_BITS_DEF,
	parameter int QUEUE_DEPTH = vuc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// tdata: func[2:0], a_x[34:3], a_y[66:35], a_unit[69:67], b_x[101:70],
	//        b_y[133:102], b_unit[136:134], target_unit[139:137], zero pad
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [vuc_pkg::IN_BYTES_W-1:0]       s_tdata,
	// tdata: result_x[31:0], result_y[63:32], result_unit[66:64],
	//        status[68:67], zero pad
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [vuc_pkg::OUT_BYTES_W-1:0]           m_tdata,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [vuc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [31:0]                          cfg_data
);

	vuc_pkg::cfg_t  cfg_q;
	vuc_pkg::work_t f_item, q_item;
	logic           q_push, q_full, q_pop, q_empty;

	assign cfg_ready = 1'b1;

	// configuration registers, written by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sw <= 16'd1920;
			cfg_q.sh <= 16'd1080;
			cfg_q.vl <= 32'd0;
			cfg_q.vt <= 32'd0;
			cfg_q.vw <= 32'h0001_0000;
			cfg_q.vh <= 32'h0001_0000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vuc_pkg::CFG_SCREEN_WIDTH:  cfg_q.sw <= cfg_data[15:0];
				vuc_pkg::CFG_SCREEN_HEIGHT: cfg_q.sh <= cfg_data[15:0];
				vuc_pkg::CFG_VIEW_LEFT:     cfg_q.vl <= cfg_data;
				vuc_pkg::CFG_VIEW_TOP:      cfg_q.vt <= cfg_data;
				vuc_pkg::CFG_VIEW_WIDTH:    cfg_q.vw <= cfg_data;
				vuc_pkg::CFG_VIEW_HEIGHT:   cfg_q.vh <= cfg_data;
				default: ;
			endcase
		end
	end

	vuc_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (f_item)
	);

	vuc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (f_item),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_item),
		.empty  (q_empty)
	);

	vuc_back #(
		.FRAC_BITS (FRAC_BITS),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// queue never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full)) else $error("queue overflow");

	// back end only takes work that is there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty) else $error("queue underflow");

	// unknown unit or function always reports a zero vector
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[68:67] == vuc_pkg::STAT_UNKNOWN) |-> (m_tdata[63:0] == 64'd0))
		else $error("unknown status with nonzero result");

endmodule
`default_nettype wire
